// ===== src/aes_pkg.sv =====
package aes_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3,
        REG_DECRYPT  = 3'd4
    } reg_index_t;

    function automatic byte_t sbox(input byte_t a);
        byte_t t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic byte_t inv_sbox(input byte_t a);
        byte_t t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic byte_t rcon(input logic [3:0] r);
        case (r)
            4'd0:    return 8'h01;
            4'd1:    return 8'h02;
            4'd2:    return 8'h04;
            4'd3:    return 8'h08;
            4'd4:    return 8'h10;
            4'd5:    return 8'h20;
            4'd6:    return 8'h40;
            4'd7:    return 8'h80;
            4'd8:    return 8'h1b;
            4'd9:    return 8'h36;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t xt(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic byte_t bsel(input block_t b, input int i);
        return b[127-8*i -: 8];
    endfunction

endpackage

// ===== src/aes_round.sv =====
// one cipher round per cycle, forward or inverse
module aes_round (
    input  aes_pkg::block_t state_in,
    input  aes_pkg::block_t round_key,
    input  logic            inverse,
    input  logic            first_step,
    input  logic            last_step,
    output aes_pkg::block_t state_out
);
    import aes_pkg::*;

    byte_t s [16];
    byte_t t [16];
    byte_t m [16];
    byte_t o [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = bsel(state_in, i);
        end
        // substitute and rotate rows
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inverse) begin
                    t[4*c+r] = inv_sbox(s[4*((c-r+4)%4)+r]);
                end else begin
                    t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
                end
            end
        end
        // forward: mix then key; inverse: key then mix
        for (int i = 0; i < 16; i++) begin
            o[i] = inverse ? (t[i] ^ bsel(round_key, i)) : t[i];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                byte_t a0, a1, a2, a3, x4, x8;
                a0 = o[4*c+r];
                a1 = o[4*c+((r+1)%4)];
                a2 = o[4*c+((r+2)%4)];
                a3 = o[4*c+((r+3)%4)];
                if (inverse) begin
                    // 0e a0 ^ 0b a1 ^ 0d a2 ^ 09 a3
                    x4 = xt(xt(a0 ^ a2));
                    x8 = xt(xt(xt(a0 ^ a1 ^ a2 ^ a3)));
                    m[4*c+r] = xt(a0 ^ a1) ^ a1 ^ a2 ^ a3 ^ x4 ^ x8;
                end else begin
                    x4 = 8'h00;
                    x8 = 8'h00;
                    m[4*c+r] = xt(a0 ^ a1) ^ a1 ^ a2 ^ a3;
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (first_step) begin
                state_out[127-8*i -: 8] = s[i] ^ bsel(round_key, i);
            end else if (last_step) begin
                state_out[127-8*i -: 8] = inverse ? o[i] : (t[i] ^ bsel(round_key, i));
            end else begin
                state_out[127-8*i -: 8] = inverse ? m[i] : (m[i] ^ bsel(round_key, i));
            end
        end
    end

endmodule

// ===== src/aes128_cbc_cipher_unit.sv =====
// channel   | ports                               | handshake
// input     | s_data_high s_data_low s_first_block | s_valid / s_ready
// result    | m_result_high m_result_low          | m_valid / m_ready
// config    | apb psel penable pwrite paddr       | pready tied high
// a block passes through the shared round unit one round per cycle, then is
// presented in the result register; the chain dependency means the next block waits for it
// a key write runs the key schedule, one round key a cycle
// aresetn is synchronous, active low; it clears control and chain state
// a stalled result holds in the output register while the next block is
// accepted; the unit waits only if that block finishes before it is taken
module aes128_cbc_cipher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_high,
    input  logic [63:0] s_data_low,
    input  logic        s_first_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import aes_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] step_reg;
    logic [3:0] kstep_reg;
    logic       kbusy_reg;
    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        decrypt_reg;
    block_t      chain_reg, state_blk_reg, data_in_reg, kw_reg;
    logic        mode_reg;
    block_t      rk_mem [11];
    block_t      rk_q;
    block_t      round_out;
    logic        m_valid_reg;
    logic [127:0] m_data_reg;

    assign pready = 1'b1;
    logic wr_en;
    logic [2:0] widx;
    assign wr_en = psel && penable && pwrite;
    assign widx  = paddr[5:3];

    // register readback
    always_comb begin
        case (widx)
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_IV_HIGH:  prdata = iv_high_reg;
            REG_IV_LOW:   prdata = iv_low_reg;
            REG_DECRYPT:  prdata = {63'd0, decrypt_reg};
            default:      prdata = 64'd0;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            decrypt_reg  <= 1'b0;
        end else if (wr_en) begin
            case (widx)
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_IV_HIGH:  iv_high_reg  <= pwdata;
                REG_IV_LOW:   iv_low_reg   <= pwdata;
                REG_DECRYPT:  decrypt_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // key schedule, one round key per cycle
    logic key_wr;
    block_t kw_start, kw_next;
    logic [31:0] kt;
    assign key_wr = wr_en && (widx == REG_KEY_HIGH || widx == REG_KEY_LOW);
    always_comb begin
        kw_start = {(widx == REG_KEY_HIGH) ? pwdata : key_high_reg,
                    (widx == REG_KEY_LOW) ? pwdata : key_low_reg};
        kt = {sbox(kw_reg[23:16]) ^ rcon(kstep_reg), sbox(kw_reg[15:8]),
              sbox(kw_reg[7:0]), sbox(kw_reg[31:24])};
        kw_next[127:96] = kw_reg[127:96] ^ kt;
        kw_next[95:64]  = kw_reg[95:64] ^ kw_next[127:96];
        kw_next[63:32]  = kw_reg[63:32] ^ kw_next[95:64];
        kw_next[31:0]   = kw_reg[31:0] ^ kw_next[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kbusy_reg <= 1'b0;
            kstep_reg <= '0;
        end else if (key_wr) begin
            kbusy_reg <= 1'b1;
            kstep_reg <= '0;
        end else if (kbusy_reg) begin
            kstep_reg <= kstep_reg + 4'd1;
            if (kstep_reg == 4'(NumRounds - 1)) begin
                kbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            kw_reg <= kw_start;
            rk_mem[0] <= kw_start;
        end else if (kbusy_reg) begin
            kw_reg <= kw_next;
            rk_mem[kstep_reg + 4'd1] <= kw_next;
        end
    end

    // round key read, registered, one step ahead
    logic [3:0] rd_addr;
    always_ff @(posedge aclk) begin
        rk_q <= rk_mem[rd_addr];
    end

    // round unit drive
    logic first_step, last_step;
    assign first_step = (step_reg == 4'd0);
    assign last_step  = (step_reg == 4'(NumRounds));

    aes_round u_round (
        .state_in   (state_blk_reg),
        .round_key  (rk_q),
        .inverse    (mode_reg),
        .first_step (first_step),
        .last_step  (last_step),
        .state_out  (round_out)
    );

    logic in_fire, out_fire;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !kbusy_reg;

    always_comb begin
        logic [3:0] nxt;
        nxt = (state_reg == ST_RUN) ? step_reg + 4'd1 : 4'd0;
        if (in_fire) begin
            nxt = 4'd0;
        end
        rd_addr = (in_fire ? decrypt_reg : mode_reg) ?
                  4'(NumRounds) - nxt : nxt;
        if (nxt > 4'(NumRounds)) begin
            rd_addr = 4'd0;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_RUN;
            ST_RUN:  if (last_step) state_next = ST_DONE;
            ST_DONE: if (!m_valid_reg || out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    block_t chain_use;
    assign chain_use = s_first_block ? {iv_high_reg, iv_low_reg} : chain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            chain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result valid: set when a block lands, cleared when taken
            if (state_reg == ST_DONE && (!m_valid_reg || out_fire)) begin
                m_valid_reg <= 1'b1;
            end else if (out_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (in_fire) begin
                        mode_reg    <= decrypt_reg;
                        data_in_reg <= {s_data_high, s_data_low};
                        state_blk_reg <= decrypt_reg ? {s_data_high, s_data_low} :
                                         ({s_data_high, s_data_low} ^ chain_use);
                        chain_reg <= chain_use;
                    end
                end
                ST_RUN: begin
                    step_reg      <= step_reg + 4'd1;
                    state_blk_reg <= round_out;
                end
                ST_DONE: begin
                    if (!m_valid_reg || out_fire) begin
                        if (mode_reg) begin
                            m_data_reg <= state_blk_reg ^ chain_reg;
                            chain_reg  <= data_in_reg;
                        end else begin
                            m_data_reg <= state_blk_reg;
                            chain_reg  <= state_blk_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_high = m_data_reg[127:64];
    assign m_result_low  = m_data_reg[63:0];

    // no new block is taken while the key schedule runs
    assert property (@(posedge aclk) disable iff (!aresetn) kbusy_reg |-> !s_ready)
        else $error("block accepted during key expansion");
    // a block reaches the done state exactly after the final round
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && last_step) |=> state_reg == ST_DONE)
        else $error("round sequencer overran");
    // the round counter never passes the final round
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> step_reg <= 4'(NumRounds))
        else $error("round counter out of range");

endmodule

// ===== tb/tb_aes128_cbc_cipher_unit.sv =====
module tb_aes128_cbc_cipher_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import aes_pkg::*;

    typedef struct {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        first_block;
    } block_txn_t;

    typedef struct {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } result_txn_t;

    localparam int IdleLimit = 20000;
    localparam int KeySettle = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data_high;
    logic [63:0] s_data_low;
    logic        s_first_block;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    aes128_cbc_cipher_unit i_dut (.*);

    // predictor state
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic        decrypting;
    logic [31:0] sched_words [44];
    logic [127:0] cbc_chain;

    block_txn_t  pending_blocks [$];
    result_txn_t expected_blocks [$];
    int          error_count;
    int          idle_cycles;
    bit          hold_sender;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    logic        s_ready_q;

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // byte substitution and gf helpers, local to the predictor
    function automatic logic [7:0] sub_byte(input logic [7:0] a, input bit inverse);
        logic [7:0] f [256];
        logic [7:0] r;
        f = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        if (!inverse) return f[a];
        // inverse found by search over the forward table
        r = 8'h00;
        for (int i = 0; i < 256; i++) if (f[i] == a) r = 8'(i);
        return r;
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // key schedule from both key halves
    task automatic expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        sched_words[0] = key_hi[63:32];
        sched_words[1] = key_hi[31:0];
        sched_words[2] = key_lo[63:32];
        sched_words[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = sched_words[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_byte(t[31:24], 0), sub_byte(t[23:16], 0),
                     sub_byte(t[15:8], 0), sub_byte(t[7:0], 0)};
                t ^= {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            sched_words[i] = sched_words[i-4] ^ t;
        end
    endtask

    function automatic logic [127:0] round_key(input int r);
        return {sched_words[4*r], sched_words[4*r+1], sched_words[4*r+2], sched_words[4*r+3]};
    endfunction

    // one aes block, forward or inverse; byte (row r, col c) at index 4c+r
    function automatic logic [127:0] aes_block(input logic [127:0] blk, input bit inverse);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] m [4];
        logic [127:0] k;
        int rnd, src;
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int step = 0; step <= 10; step++) begin
            rnd = inverse ? 10 - step : step;
            if (step > 0) begin
                for (int i = 0; i < 16; i++) s[i] = sub_byte(s[i], inverse);
                t = s;
                for (int r = 1; r < 4; r++)
                    for (int c = 0; c < 4; c++) begin
                        src = inverse ? ((c - r + 4) & 3) : ((c + r) & 3);
                        s[4*c+r] = t[4*src+r];
                    end
                if (!inverse && step < 10) begin
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++) begin
                            s[4*c+r] = 8'h00;
                            for (int j = 0; j < 4; j++)
                                s[4*c+r] ^= gmul(t[4*c+j], m[(j - r + 4) & 3]);
                        end
                end
            end
            k = round_key(rnd);
            for (int i = 0; i < 16; i++) s[i] ^= k[127-8*i -: 8];
            if (inverse && step > 0 && step < 10) begin
                t = s;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        s[4*c+r] = 8'h00;
                        for (int j = 0; j < 4; j++)
                            s[4*c+r] ^= gmul(t[4*c+j], m[(j - r + 4) & 3]);
                    end
            end
        end
        for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
        return blk;
    endfunction

    // append helpers for the two queues
    task automatic add_expected(input result_txn_t e);
        expected_blocks.insert(expected_blocks.size(), e);
    endtask

    task automatic add_pending(input block_txn_t b);
        pending_blocks.insert(pending_blocks.size(), b);
    endtask

    // cbc step for one accepted transaction
    task automatic predict_cbc(input block_txn_t b);
        logic [127:0] din, dout;
        result_txn_t  e;
        din = {b.data_high, b.data_low};
        if (b.first_block) cbc_chain = {iv_hi, iv_lo};
        if (decrypting) begin
            dout = aes_block(din, 1) ^ cbc_chain;
            cbc_chain = din;
        end else begin
            dout = aes_block(din ^ cbc_chain, 0);
            cbc_chain = dout;
        end
        e.result_high = dout[127:64];
        e.result_low = dout[63:0];
        add_expected(e);
    endtask

    // apb register write, changes on falling edge
    task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * int'(idx));
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KEY_HIGH: begin key_hi = val; expand_schedule(); end
            REG_KEY_LOW:  begin key_lo = val; expand_schedule(); end
            REG_IV_HIGH:  iv_hi = val;
            REG_IV_LOW:   iv_lo = val;
            REG_DECRYPT:  decrypting = val[0];
            default: ;
        endcase
        repeat (KeySettle) @(negedge aclk);
    endtask

    task automatic drain_results();
        while (pending_blocks.size() != 0 || s_valid) @(negedge aclk);
        while (expected_blocks.size() != 0) @(negedge aclk);
        repeat (KeySettle) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] field_value();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo, input logic fb);
        block_txn_t b;
        b.data_high = hi;
        b.data_low = lo;
        b.first_block = fb;
        add_pending(b);
    endtask

    // configure, then run a chain of random messages
    task automatic run_phase(input int n_items, input bit mode);
        int msg_left;
        write_reg(REG_KEY_HIGH, field_value());
        write_reg(REG_KEY_LOW, field_value());
        write_reg(REG_IV_HIGH, field_value());
        write_reg(REG_IV_LOW, field_value());
        write_reg(REG_DECRYPT, 64'(mode));
        msg_left = 0;
        for (int i = 0; i < n_items; i++) begin
            queue_block(field_value(), field_value(), msg_left == 0);
            msg_left = (msg_left == 0) ? $urandom_range(0, 12) : msg_left - 1;
        end
        drain_results();
    endtask

    // driver: bursts and gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_q) begin
            if (pending_blocks.size() != 0 && !hold_sender && gap_left == 0) begin
                s_valid <= 1'b1;
                s_data_high <= pending_blocks[0].data_high;
                s_data_low <= pending_blocks[0].data_low;
                s_first_block <= pending_blocks[0].first_block;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                end
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 30);
            end else begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
        // receiver stall pattern
        stall_phase = (stall_phase + 1) % 200;
        if (stall_phase < 60) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 37 > 5);
    end

    // acceptance captured at the rising edge
    always @(posedge aclk) begin
        s_ready_q <= 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s_ready_q <= 1'b1;
                predict_cbc(pending_blocks.pop_front());
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_txn_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected transaction result_high=%h result_low=%h",
                       m_result_high, m_result_low);
                error_count++;
            end else begin
                e = expected_blocks.pop_front();
                if (m_result_high !== e.result_high) begin
                    $error("result_high expected %h actual %h", e.result_high, m_result_high);
                    error_count++;
                end
                if (m_result_low !== e.result_low) begin
                    $error("result_low expected %h actual %h", e.result_low, m_result_low);
                    error_count++;
                end
            end
        end
    end

    // idle count, cleared by any accepted transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_cycles > IdleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_high = '0;
        s_data_low = '0;
        s_first_block = 1'b0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        key_hi = '0;
        key_lo = '0;
        iv_hi = '0;
        iv_lo = '0;
        decrypting = 1'b0;
        cbc_chain = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_sender = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        expand_schedule();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // fips-197 vector; no first block so the chain starts at zero
        write_reg(REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        queue_block(64'h0, 64'h0, 1'b0);
        queue_block('1, '1, 1'b0);
        drain_results();
        // all-ones key and iv, chain restart mid-stream
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_IV_HIGH, '1);
        write_reg(REG_IV_LOW, '1);
        queue_block('1, 64'h0, 1'b1);
        queue_block(64'h0, '1, 1'b0);
        queue_block(64'h8000000000000001, 64'h0123456789abcdef, 1'b1);
        drain_results();
        // decrypt with zero key, iv changed, one key half rewritten
        write_reg(REG_DECRYPT, 64'h1);
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_KEY_LOW, '0);
        write_reg(REG_IV_HIGH, 64'h0);
        queue_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        queue_block('1, '1, 1'b0);
        queue_block(64'h0, 64'h0, 1'b1);
        drain_results();
        write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        queue_block(64'hfedcba9876543210, '0, 1'b0);
        queue_block('0, 64'h1, 1'b1);
        drain_results();

        // random phases alternating mode
        for (int p = 0; p < 10; p++) begin
            if (p == 5) begin
                // sender holds mid-stream until every result is back
                for (int i = 0; i < 6; i++) queue_block(rand64(), rand64(), i == 0);
                while (pending_blocks.size() > 3) @(negedge aclk);
                hold_sender = 1'b1;
                while (s_valid || expected_blocks.size() != 0) @(negedge aclk);
                hold_sender = 1'b0;
                drain_results();
            end
            run_phase(153, p[0]);
        end
        drain_results();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/aes_pkg.sv
src/aes_round.sv
src/aes128_cbc_cipher_unit.sv
tb/tb_aes128_cbc_cipher_unit.sv
